FILE: rtl/ddfh_pkg.sv
// ----------------------------------------------------------------------------
// ddfh_pkg: shared constants and helpers for the decimal digit fold hash
// Field widths, stream packing, the reciprocal used for division by ten
// and the mod-ten digit add.
// ----------------------------------------------------------------------------
package ddfh_pkg;

  localparam int KEY_W        = 31;
  localparam int CNT_W        = 4;
  localparam int OUT_W        = 31;
  localparam int DIGIT_W      = 4;
  localparam int S_TDATA_W    = 40;
  localparam int M_TDATA_W    = 32;
  localparam int MAX_DIGITS_DEF = 10;

  localparam int RECIP_W      = 32;
  localparam logic [RECIP_W-1:0] RECIP = 32'hCCCC_CCCD;
  localparam int RECIP_SHIFT  = 35;
  localparam int PROD_W       = KEY_W + RECIP_W;
  localparam int QUOT_W       = PROD_W - RECIP_SHIFT;

  localparam int RES_W        = 7;

  typedef logic [DIGIT_W-1:0] digit_t;

  function automatic logic [PROD_W-1:0] mul_recip(input logic [KEY_W-1:0] val);
    mul_recip = {{(PROD_W-KEY_W){1'b0}}, val} * {{(PROD_W-RECIP_W){1'b0}}, RECIP};
  endfunction

  function automatic digit_t add_mod10(input digit_t a, input digit_t b);
    logic [DIGIT_W:0] sum;
    sum = {1'b0, a} + {1'b0, b};
    if (sum >= (DIGIT_W+1)'(10)) begin
      sum = sum - (DIGIT_W+1)'(10);
    end
    add_mod10 = sum[DIGIT_W-1:0];
  endfunction

endpackage

FILE: rtl/decimal_digit_fold_hash.sv
// ----------------------------------------------------------------------------
// decimal_digit_fold_hash: digit folding hash of a nonnegative key
// Splits the key into decimal digits one per cycle and folds pairs of them
// with mod-ten adds, one fold pass per cycle.
// ----------------------------------------------------------------------------
// channel   dir  tdata (low bit first)                tuser  tlast
// s_axis    in   key[30:0], digit_count[34:31], pad   -      -
// m_axis    out  bucket_index[30:0], pad              -      -
//
// An item with digit count t of 3 or more runs t digit steps through the
// divide-by-ten unit, t/2-1 fold passes and a result step that forms the
// index once the output register is free. Counts of 0, 1 or 2 go straight
// to the result step and pass the key through. s_axis_tready is high only
// while idle; one finished result may wait in the output register while
// the next item is taken. Reset clears control state only.
// ----------------------------------------------------------------------------
module decimal_digit_fold_hash #(
  parameter int MAX_DIGITS = ddfh_pkg::MAX_DIGITS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [ddfh_pkg::S_TDATA_W-1:0]    s_axis_tdata,  // key, digit_count
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [ddfh_pkg::M_TDATA_W-1:0]    m_axis_tdata   // bucket_index
);

  localparam int DCNT_W = $clog2(MAX_DIGITS + 1);
  localparam int PASS_W = $clog2(MAX_DIGITS / 2 + 1);
  localparam int SR_N   = (MAX_DIGITS < 4) ? 4 : MAX_DIGITS;

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_DIGIT  = 2'd1;
  localparam logic [1:0] ST_FOLD   = 2'd2;
  localparam logic [1:0] ST_RESULT = 2'd3;

  logic [1:0]                        state_q, state_d;
  logic [DCNT_W-1:0]                 t_q, t_d;
  logic [DCNT_W-1:0]                 dcnt_q, dcnt_d;
  logic [PASS_W-1:0]                 pcnt_q, pcnt_d;
  logic                              pass_key_q, pass_key_d;
  logic [ddfh_pkg::KEY_W-1:0]        key_q, key_d;
  logic [ddfh_pkg::KEY_W-1:0]        val_q, val_d;
  logic [ddfh_pkg::PROD_W-1:0]       prod_q, prod_d;
  ddfh_pkg::digit_t                  sr_q [SR_N];
  ddfh_pkg::digit_t                  sr_d [SR_N];
  logic                              m_valid_q, m_valid_d;
  logic [ddfh_pkg::OUT_W-1:0]        m_data_q, m_data_d;

  logic [ddfh_pkg::KEY_W-1:0]        in_key;
  logic [ddfh_pkg::CNT_W-1:0]        in_cnt;
  logic [DCNT_W-1:0]                 t_clamp;
  logic [PASS_W-1:0]                 passes;
  logic                              in_acc;
  logic [ddfh_pkg::KEY_W-1:0]        quot;
  ddfh_pkg::digit_t                  digit;
  logic [ddfh_pkg::PROD_W-1:0]       prod_next;
  ddfh_pkg::digit_t                  fold_hi, fold_lo;
  ddfh_pkg::digit_t                  res_hi, res_lo;
  logic [ddfh_pkg::RES_W-1:0]        res;
  logic                              out_free;

  assign in_key = s_axis_tdata[ddfh_pkg::KEY_W-1:0];
  assign in_cnt = s_axis_tdata[ddfh_pkg::KEY_W+ddfh_pkg::CNT_W-1:ddfh_pkg::KEY_W];
  assign in_acc = s_axis_tvalid & s_axis_tready;

  always_comb begin
    if (in_cnt == '0) begin
      t_clamp = DCNT_W'(1);
    end else if (in_cnt > ddfh_pkg::CNT_W'(MAX_DIGITS)) begin
      t_clamp = DCNT_W'(MAX_DIGITS);
    end else begin
      t_clamp = DCNT_W'(in_cnt);
    end
  end

  assign passes = PASS_W'((t_q >> 1) - DCNT_W'(1));

  ddfh_div10 u_div10 (
    .val_i   (val_q),
    .prod_i  (prod_q),
    .quot_o  (quot),
    .digit_o (digit),
    .prod_o  (prod_next)
  );

  assign fold_hi = ddfh_pkg::add_mod10(sr_q[0], sr_q[3]);
  assign fold_lo = ddfh_pkg::add_mod10(sr_q[1], sr_q[2]);

  assign res_hi = t_q[0] ? sr_q[1] : sr_q[0];
  assign res_lo = t_q[0] ? sr_q[2] : sr_q[1];
  assign res    = ({3'b000, res_hi} << 3) + ({3'b000, res_hi} << 1) + {3'b000, res_lo};

  assign out_free = ~m_valid_q | m_axis_tready;

  always_comb begin
    state_d    = state_q;
    t_d        = t_q;
    dcnt_d     = dcnt_q;
    pcnt_d     = pcnt_q;
    pass_key_d = pass_key_q;
    key_d      = key_q;
    val_d      = val_q;
    prod_d     = prod_q;
    sr_d       = sr_q;
    m_valid_d  = m_valid_q;
    m_data_d   = m_data_q;

    if (m_valid_q && m_axis_tready) begin
      m_valid_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          key_d      = in_key;
          val_d      = in_key;
          prod_d     = ddfh_pkg::mul_recip(in_key);
          t_d        = t_clamp;
          dcnt_d     = t_clamp;
          pass_key_d = (t_clamp <= DCNT_W'(2));
          state_d    = (t_clamp <= DCNT_W'(2)) ? ST_RESULT : ST_DIGIT;
        end
      end
      ST_DIGIT: begin
        for (int i = SR_N - 1; i > 0; i--) begin
          sr_d[i] = sr_q[i-1];
        end
        sr_d[0] = digit;
        val_d   = quot;
        prod_d  = prod_next;
        dcnt_d  = dcnt_q - DCNT_W'(1);
        if (dcnt_q == DCNT_W'(1)) begin
          pcnt_d  = passes;
          state_d = (passes == '0) ? ST_RESULT : ST_FOLD;
        end
      end
      ST_FOLD: begin
        sr_d[0] = fold_lo;
        sr_d[1] = fold_hi;
        for (int i = 2; i < SR_N - 2; i++) begin
          sr_d[i] = sr_q[i+2];
        end
        pcnt_d = pcnt_q - PASS_W'(1);
        if (pcnt_q == PASS_W'(1)) begin
          state_d = ST_RESULT;
        end
      end
      ST_RESULT: begin
        if (out_free) begin
          m_valid_d = 1'b1;
          m_data_d  = pass_key_q ? key_q
                                 : {{(ddfh_pkg::OUT_W-ddfh_pkg::RES_W){1'b0}}, res};
          state_d   = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      m_valid_q <= 1'b0;
      dcnt_q    <= '0;
      pcnt_q    <= '0;
    end else begin
      state_q   <= state_d;
      m_valid_q <= m_valid_d;
      dcnt_q    <= dcnt_d;
      pcnt_q    <= pcnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    t_q        <= t_d;
    pass_key_q <= pass_key_d;
    key_q      <= key_d;
    val_q      <= val_d;
    prod_q     <= prod_d;
    sr_q       <= sr_d;
    m_data_q   <= m_data_d;
  end

  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {{(ddfh_pkg::M_TDATA_W-ddfh_pkg::OUT_W){1'b0}}, m_data_q};

`ifndef SYNTHESIS
  a_busy_not_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_IDLE) |-> !s_axis_tready)
    else $error("input taken while busy");

  a_digit_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIGIT) |-> (digit < ddfh_pkg::DIGIT_W'(10)))
    else $error("extracted digit out of range");

  a_fold_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_RESULT && !pass_key_q) |-> (res < ddfh_pkg::RES_W'(100)))
    else $error("folded index out of range");
`endif

endmodule

FILE: rtl/ddfh_div10.sv
// ----------------------------------------------------------------------------
// ddfh_div10: one step of decimal digit extraction
// Takes the value and its registered product with the reciprocal of ten,
// gives the quotient, the remainder digit and the quotient's own product.
// ----------------------------------------------------------------------------
module ddfh_div10 (
  input  logic [ddfh_pkg::KEY_W-1:0]  val_i,
  input  logic [ddfh_pkg::PROD_W-1:0] prod_i,
  output logic [ddfh_pkg::KEY_W-1:0]  quot_o,
  output ddfh_pkg::digit_t            digit_o,
  output logic [ddfh_pkg::PROD_W-1:0] prod_o
);

  logic [ddfh_pkg::QUOT_W-1:0] quot;
  logic [ddfh_pkg::KEY_W-1:0]  quot_ext;
  logic [ddfh_pkg::KEY_W-1:0]  quot_x10;
  logic [ddfh_pkg::KEY_W-1:0]  rem;

  assign quot     = prod_i[ddfh_pkg::PROD_W-1:ddfh_pkg::RECIP_SHIFT];
  assign quot_ext = {{(ddfh_pkg::KEY_W-ddfh_pkg::QUOT_W){1'b0}}, quot};
  assign quot_x10 = (quot_ext << 3) + (quot_ext << 1);
  assign rem      = val_i - quot_x10;

  assign quot_o  = quot_ext;
  assign digit_o = rem[ddfh_pkg::DIGIT_W-1:0];
  assign prod_o  = ddfh_pkg::mul_recip(quot_ext);

endmodule

FILE: tb/decimal_digit_fold_hash_test.sv
// ----------------------------------------------------------------------------
// decimal_digit_fold_hash_test: stream-level check of the digit fold hash
// Drives keys and digit counts into the slave port with random gaps and
// checks every bucket index from the master port against a predictor of
// the digit folding. The receiver stalls at random and once for a long
// stretch. The sender drains the block to empty at three points.
// ----------------------------------------------------------------------------
class fold_checker;
  localparam int NDIG = ddfh_pkg::MAX_DIGITS_DEF;

  logic [ddfh_pkg::OUT_W-1:0] pending_index[$];
  int mismatches = 0;
  int matched = 0;
  int keys_seen = 0;

  function logic [ddfh_pkg::OUT_W-1:0] fold_index(input logic [ddfh_pkg::KEY_W-1:0] key,
                                                  input logic [ddfh_pkg::CNT_W-1:0] cnt);
    longint unsigned d[NDIG];
    longint unsigned rest, p, e1, e2;
    int unsigned t;
    int j, n, k, hi, lo;
    t = cnt;
    if (t < 1) t = 1;
    if (t > NDIG) t = NDIG;
    if (t <= 2) return key;
    rest = key;
    for (j = 0; j < t; j++) begin
      p = 1;
      for (n = 0; n < t - 1 - j; n++) p = p * 10;
      d[j] = rest / p;
      rest = rest % p;
    end
    e1 = d[0];
    e2 = d[1];
    for (k = 0; k < t / 2 - 1; k++) begin
      hi = 3 + 2 * k;
      lo = 2 + 2 * k;
      d[hi] = (e1 + d[hi]) % 10;
      d[lo] = (e2 + d[lo]) % 10;
      e1 = d[lo];
      e2 = d[hi];
    end
    return ddfh_pkg::OUT_W'(d[t-2] * 10 + d[t-1]);
  endfunction

  function void note_key(input logic [ddfh_pkg::KEY_W-1:0] key,
                         input logic [ddfh_pkg::CNT_W-1:0] cnt);
    pending_index.push_back(fold_index(key, cnt));
    keys_seen++;
  endfunction

  function void check_index(input logic [ddfh_pkg::OUT_W-1:0] got);
    logic [ddfh_pkg::OUT_W-1:0] want;
    if (pending_index.size() == 0) begin
      $error("bucket_index: expected none pending, actual %0d", got);
      mismatches++;
      return;
    end
    want = pending_index.pop_front();
    if (got !== want) begin
      $error("bucket_index: expected %0d, actual %0d", want, got);
      mismatches++;
    end else begin
      matched++;
    end
  endfunction
endclass

module decimal_digit_fold_hash_test;

  localparam int CYCLE_LIMIT = 500000;
  localparam int HOLD_CYCLES = 300;
  localparam int TAIL_CYCLES = 40;
  localparam int RANDOM_ITEMS = 1080;
  localparam logic [ddfh_pkg::KEY_W-1:0] KEY_MAX = {ddfh_pkg::KEY_W{1'b1}};

  logic clk_i = 1'b0;
  logic rst_ni;
  logic s_axis_tvalid;
  logic s_axis_tready;
  logic [ddfh_pkg::S_TDATA_W-1:0] s_axis_tdata;
  logic m_axis_tvalid;
  logic m_axis_tready;
  logic [ddfh_pkg::M_TDATA_W-1:0] m_axis_tdata;

  fold_checker chk = new();
  bit hold_off_req = 1'b0;
  bit hold_off_done = 1'b0;
  int cycles = 0;

  decimal_digit_fold_hash dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  initial begin
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("[decimal_digit_fold_hash] ERROR");
    $finish;
  end

  task automatic offer(input logic [ddfh_pkg::KEY_W-1:0] key,
                       input logic [ddfh_pkg::CNT_W-1:0] cnt,
                       input int gap);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {{(ddfh_pkg::S_TDATA_W-ddfh_pkg::KEY_W-ddfh_pkg::CNT_W){1'b0}},
                      cnt, key};
    do @(posedge clk_i); while (!s_axis_tready);
    chk.note_key(key, cnt);
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (chk.pending_index.size() != 0) @(posedge clk_i);
  endtask

  function automatic logic [ddfh_pkg::KEY_W-1:0] pick_key();
    longint unsigned p;
    int e;
    p = 1;
    case ($urandom_range(0, 4))
      0: return ddfh_pkg::KEY_W'($urandom_range(0, 999));
      1: begin
        e = $urandom_range(1, 9);
        repeat (e) p = p * 10;
        return ddfh_pkg::KEY_W'(p - 2 + $urandom_range(0, 3));
      end
      2: return ddfh_pkg::KEY_W'(KEY_MAX - $urandom_range(0, 1000));
      default: return ddfh_pkg::KEY_W'($urandom());
    endcase
  endfunction

  function automatic logic [ddfh_pkg::CNT_W-1:0] pick_count();
    if ($urandom_range(0, 3) == 0) return ddfh_pkg::CNT_W'($urandom_range(0, 15));
    return ddfh_pkg::CNT_W'($urandom_range(3, 10));
  endfunction

  initial begin
    bit fast_rx;
    int gap;
    fast_rx = 1'b0;
    m_axis_tready <= 1'b0;
    do @(posedge clk_i); while (!rst_ni);
    forever begin
      if (chk.matched % 64 == 0) fast_rx = ($urandom_range(0, 3) == 0);
      gap = fast_rx ? 0 : $urandom_range(0, 16);
      if (hold_off_req && !hold_off_done) begin
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        hold_off_done = 1'b1;
      end else if (gap > 0) begin
        m_axis_tready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
      chk.check_index(m_axis_tdata[ddfh_pkg::OUT_W-1:0]);
    end
  end

  initial begin
    logic [ddfh_pkg::KEY_W-1:0] dir_key[$];
    logic [ddfh_pkg::CNT_W-1:0] dir_cnt[$];
    bit burst;
    int i;
    rst_ni        <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // zero count, saturated counts, count of three, extreme keys
    dir_key = '{0, KEY_MAX, KEY_MAX, 12, KEY_MAX, 123456, KEY_MAX, KEY_MAX,
                1234567890, KEY_MAX, 999999999, KEY_MAX, 2000000000, KEY_MAX,
                KEY_MAX, 1999999999, 0, 9, 1000000000, 5, 0, 987654321};
    dir_cnt = '{0, 0, 1, 2, 2, 3, 3, 4, 5, 6, 7, 8, 9, 10, 11, 15, 10, 12,
                10, 13, 14, 10};
    for (i = 0; i < dir_key.size(); i++) offer(dir_key[i], dir_cnt[i], $urandom_range(0, 3));
    drain();

    burst = 1'b0;
    for (i = 0; i < RANDOM_ITEMS; i++) begin
      if (i % 100 == 0) burst = ($urandom_range(0, 2) == 0);
      if (i == 100) hold_off_req = 1'b1;
      if (i == RANDOM_ITEMS / 2) drain();
      offer(pick_key(), pick_count(), burst ? 0 : $urandom_range(0, 16));
    end
    drain();
    repeat (TAIL_CYCLES) @(posedge clk_i);

    $display("covered %0d keys, counts 0..15 with extreme keys, %0d indexes matched",
             chk.keys_seen, chk.matched);
    $display("receiver held off %0d cycles once; block drained to empty three times",
             HOLD_CYCLES);
    if (chk.mismatches == 0 && chk.pending_index.size() == 0) begin
      $display("[decimal_digit_fold_hash] OK");
    end else begin
      $display("[decimal_digit_fold_hash] ERROR");
    end
    $finish;
  end
endmodule
